// ===== src/sgi_pkg.sv =====
// Shared types and constants for the segment intersection core.
`timescale 1ns / 1ps
package sgi_pkg;

    // Number of endpoint coordinates carried with each item.
    localparam int NUM_PTS = 8;

    // Coordinate slots in the endpoint array.
    localparam int PT_AX1 = 0;
    localparam int PT_AY1 = 1;
    localparam int PT_AX2 = 2;
    localparam int PT_AY2 = 3;
    localparam int PT_BX1 = 4;
    localparam int PT_BY1 = 5;
    localparam int PT_BX2 = 6;
    localparam int PT_BY2 = 7;

    // Sign and overflow flags that travel down the divider.
    typedef struct packed {
        logic neg;
        logic ovf;
    } t_dflag;

    // Hit and parallel flags that travel beside the divider.
    typedef struct packed {
        logic hit;
        logic par;
    } t_side;

endpackage

// ===== src/sgi_coef.sv =====
// Four-stage front end: line coefficients, determinant and Cramer numerators.
`timescale 1ns / 1ps
module sgi_coef #(
    parameter int CW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [CW-1:0]     i_pt [sgi_pkg::NUM_PTS],
    output logic                     o_valid,
    output logic signed [CW-1:0]     o_pt [sgi_pkg::NUM_PTS],
    output logic signed [2*CW+2:0]   o_det,
    output logic signed [3*CW+2:0]   o_num_x,
    output logic signed [3*CW+2:0]   o_num_y
);
    import sgi_pkg::*;

    localparam int AW  = CW + 1;
    localparam int PPW = 2 * CW;
    localparam int CPW = 2 * CW + 1;
    localparam int MDW = 2 * AW;
    localparam int DW  = 2 * AW + 1;
    localparam int QW  = CPW + AW;
    localparam int NW  = QW + 1;

    logic [3:0] r_vld;

    logic signed [CW-1:0]  r1_pt [NUM_PTS];
    logic signed [CW-1:0]  r2_pt [NUM_PTS];
    logic signed [CW-1:0]  r3_pt [NUM_PTS];
    logic signed [CW-1:0]  r4_pt [NUM_PTS];

    logic signed [AW-1:0]  r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [PPW-1:0] r1_p1, r1_p2, r1_p3, r1_p4;
    logic signed [AW-1:0]  r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [CPW-1:0] r2_c1, r2_c2;
    logic signed [MDW-1:0] r2_m1, r2_m2;
    logic signed [DW-1:0]  r3_d;
    logic signed [QW-1:0]  r3_q1, r3_q2, r3_q3, r3_q4;
    logic signed [DW-1:0]  r4_d;
    logic signed [NW-1:0]  r4_nx, r4_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage 1: direction terms and the cross products for c.
            r1_pt <= i_pt;
            r1_a1 <= i_pt[PT_AY2] - i_pt[PT_AY1];
            r1_b1 <= i_pt[PT_AX1] - i_pt[PT_AX2];
            r1_a2 <= i_pt[PT_BY2] - i_pt[PT_BY1];
            r1_b2 <= i_pt[PT_BX1] - i_pt[PT_BX2];
            r1_p1 <= i_pt[PT_AY1] * i_pt[PT_AX2];
            r1_p2 <= i_pt[PT_AX1] * i_pt[PT_AY2];
            r1_p3 <= i_pt[PT_BY1] * i_pt[PT_BX2];
            r1_p4 <= i_pt[PT_BX1] * i_pt[PT_BY2];
            // Stage 2: c terms and the determinant products.
            r2_pt <= r1_pt;
            r2_a1 <= r1_a1;
            r2_b1 <= r1_b1;
            r2_a2 <= r1_a2;
            r2_b2 <= r1_b2;
            r2_c1 <= r1_p1 - r1_p2;
            r2_c2 <= r1_p3 - r1_p4;
            r2_m1 <= r1_a1 * r1_b2;
            r2_m2 <= r1_a2 * r1_b1;
            // Stage 3: determinant and the numerator products.
            r3_pt <= r2_pt;
            r3_d  <= r2_m1 - r2_m2;
            r3_q1 <= r2_c2 * r2_b1;
            r3_q2 <= r2_c1 * r2_b2;
            r3_q3 <= r2_a2 * r2_c1;
            r3_q4 <= r2_a1 * r2_c2;
            // Stage 4: numerators.
            r4_pt <= r3_pt;
            r4_d  <= r3_d;
            r4_nx <= r3_q1 - r3_q2;
            r4_ny <= r3_q3 - r3_q4;
        end
    end

    assign o_valid = r_vld[3];
    assign o_pt    = r4_pt;
    assign o_det   = r4_d;
    assign o_num_x = r4_nx;
    assign o_num_y = r4_ny;

endmodule

// ===== src/sgi_divstep.sv =====
// One registered restoring-division step producing one quotient bit.
`timescale 1ns / 1ps
module sgi_divstep #(
    parameter int DW = 35,
    parameter int OW = 24
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DW-1:0]         i_rem,
    input  logic [OW-1:0]         i_low,
    input  logic [OW-1:0]         i_quo,
    input  logic [DW-1:0]         i_dm,
    input  sgi_pkg::t_dflag       i_flag,
    output logic [DW-1:0]         o_rem,
    output logic [OW-1:0]         o_low,
    output logic [OW-1:0]         o_quo,
    output logic [DW-1:0]         o_dm,
    output sgi_pkg::t_dflag       o_flag
);
    import sgi_pkg::*;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_trial = {i_rem, i_low[OW-1]};
    assign w_diff  = w_trial - {1'b0, i_dm};
    assign w_ge    = (w_trial >= {1'b0, i_dm});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            o_low  <= {i_low[OW-2:0], 1'b0};
            o_quo  <= {i_quo[OW-2:0], w_ge};
            o_dm   <= i_dm;
            o_flag <= i_flag;
        end
    end

endmodule

// ===== src/sgi_div.sv =====
// Pipelined signed fixed-point divider with truncation toward zero and saturation.
`timescale 1ns / 1ps
module sgi_div #(
    parameter int NW   = 51,
    parameter int DW   = 35,
    parameter int OW   = 24,
    parameter int FRAC = 8
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [OW-1:0] o_quo
);
    import sgi_pkg::*;

    localparam int MW = NW + FRAC;
    localparam int HW = MW - OW;
    localparam int XW = (HW > DW) ? HW : DW;
    localparam logic [OW-1:0] LIM = OW'(1) << (OW - 1);

    logic [MW-1:0]  r_mag;
    logic [DW-1:0]  r_dm0;
    logic           r_neg;

    logic [DW-1:0]  r_rem0;
    logic [OW-1:0]  r_low0;
    logic [DW-1:0]  r_dm1;
    t_dflag         r_flag0;

    logic [DW-1:0]  w_rem  [OW+1];
    logic [OW-1:0]  w_low  [OW+1];
    logic [OW-1:0]  w_quo  [OW+1];
    logic [DW-1:0]  w_dm   [OW+1];
    t_dflag         w_flag [OW+1];

    logic [NW-1:0]  w_nmag;
    logic [HW-1:0]  w_hi;
    logic [OW-1:0]  w_q;
    t_dflag         w_qf;
    logic [OW-1:0]  w_sat;

    assign w_nmag = i_num[NW-1] ? -i_num : i_num;
    assign w_hi   = r_mag[MW-1:OW];

    // Magnitudes and result sign.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= MW'(w_nmag) << FRAC;
            r_dm0 <= i_den[DW-1] ? -i_den : i_den;
            r_neg <= i_num[NW-1] ^ i_den[DW-1];
        end
    end

    // Seed the remainder with the high part; a high part not below the
    // divisor means the quotient cannot fit the output.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0      <= DW'(w_hi);
            r_low0      <= r_mag[OW-1:0];
            r_dm1       <= r_dm0;
            r_flag0.neg <= r_neg;
            r_flag0.ovf <= (XW'(w_hi) >= XW'(r_dm0));
        end
    end

    assign w_rem[0]  = r_rem0;
    assign w_low[0]  = r_low0;
    assign w_quo[0]  = '0;
    assign w_dm[0]   = r_dm1;
    assign w_flag[0] = r_flag0;

    for (genvar g = 0; g < OW; g++) begin : g_step
        sgi_divstep #(
            .DW (DW),
            .OW (OW)
        ) u_step (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rem  (w_rem[g]),
            .i_low  (w_low[g]),
            .i_quo  (w_quo[g]),
            .i_dm   (w_dm[g]),
            .i_flag (w_flag[g]),
            .o_rem  (w_rem[g+1]),
            .o_low  (w_low[g+1]),
            .o_quo  (w_quo[g+1]),
            .o_dm   (w_dm[g+1]),
            .o_flag (w_flag[g+1])
        );
    end

    assign w_q  = w_quo[OW];
    assign w_qf = w_flag[OW];

    always_comb begin
        if (w_qf.neg) begin
            w_sat = (w_qf.ovf || (w_q > LIM)) ? LIM : (~w_q + OW'(1));
        end else begin
            w_sat = (w_qf.ovf || w_q[OW-1]) ? ~LIM : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= w_sat;
        end
    end

endmodule

// ===== src/segment_intersection_core.sv =====
// Top level of the segment intersection core.
`timescale 1ns / 1ps
// Finds where the lines through two segments cross, by Cramer's rule on
// integer coordinates, and reports the point in signed fixed point with
// FRAC_BITS fraction bits, truncated toward zero and saturated. The hit flag
// says whether the exact point lies inside both segments' closed bounding
// boxes. A zero determinant marks the pair as parallel, with hit low and both
// coordinates zero. The core is fully pipelined and takes one item every
// cycle while no finished item is held at the output; the restoring divider
// spends one register stage on each quotient bit. The whole pipeline
// advances together, so a stall at the output holds every stage and raises
// o_stall on the input in the same cycle.
module segment_intersection_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_BITS-1:0]        i_seg_a_start_x,
    input  logic signed [COORD_BITS-1:0]        i_seg_a_start_y,
    input  logic signed [COORD_BITS-1:0]        i_seg_a_end_x,
    input  logic signed [COORD_BITS-1:0]        i_seg_a_end_y,
    input  logic signed [COORD_BITS-1:0]        i_seg_b_start_x,
    input  logic signed [COORD_BITS-1:0]        i_seg_b_start_y,
    input  logic signed [COORD_BITS-1:0]        i_seg_b_end_x,
    input  logic signed [COORD_BITS-1:0]        i_seg_b_end_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic                                o_is_parallel,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_cross_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_cross_y
);
    import sgi_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int OW = COORD_BITS + FRAC_BITS;
    localparam int DW = 2 * CW + 3;
    localparam int NW = 3 * CW + 3;
    localparam int PW = CW + DW + 1;
    localparam int NR = 4;

    logic                  w_en;
    logic signed [CW-1:0]  w_pt [NUM_PTS];
    logic                  w_cvalid;
    logic signed [CW-1:0]  w_cpt [NUM_PTS];
    logic signed [DW-1:0]  w_det;
    logic signed [NW-1:0]  w_nx, w_ny;
    logic signed [OW-1:0]  w_qx, w_qy;

    logic [OW+3:0]         r_vchain;

    // Bounding-box test, stage one: scaled box edges.
    logic [DW-1:0]         w_dm;
    logic signed [NW:0]    w_snx, w_sny;
    logic signed [CW-1:0]  w_lo [NR];
    logic signed [CW-1:0]  w_hi [NR];
    logic signed [PW-1:0]  r5_lo [NR];
    logic signed [PW-1:0]  r5_hi [NR];
    logic signed [NW:0]    r5_nx, r5_ny;
    logic                  r5_par;
    logic                  w_in_box;
    t_side                 r6_side;
    t_side                 r_side_dly [OW+1];

    logic                  r_hit, r_par;
    logic signed [OW-1:0]  r_cx, r_cy;

    // One enable moves every stage; it drops only while a finished item
    // waits at the output.
    assign o_stall = o_valid & i_stall;
    assign w_en    = ~o_stall;

    assign w_pt[PT_AX1] = i_seg_a_start_x;
    assign w_pt[PT_AY1] = i_seg_a_start_y;
    assign w_pt[PT_AX2] = i_seg_a_end_x;
    assign w_pt[PT_AY2] = i_seg_a_end_y;
    assign w_pt[PT_BX1] = i_seg_b_start_x;
    assign w_pt[PT_BY1] = i_seg_b_start_y;
    assign w_pt[PT_BX2] = i_seg_b_end_x;
    assign w_pt[PT_BY2] = i_seg_b_end_y;

    sgi_coef #(
        .CW (CW)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_pt    (w_pt),
        .o_valid (w_cvalid),
        .o_pt    (w_cpt),
        .o_det   (w_det),
        .o_num_x (w_nx),
        .o_num_y (w_ny)
    );

    sgi_div #(
        .NW   (NW),
        .DW   (DW),
        .OW   (OW),
        .FRAC (FRAC_BITS)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_nx),
        .i_den (w_det),
        .o_quo (w_qx)
    );

    sgi_div #(
        .NW   (NW),
        .DW   (DW),
        .OW   (OW),
        .FRAC (FRAC_BITS)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_ny),
        .i_den (w_det),
        .o_quo (w_qy)
    );

    // The box test compares n * sign(d) against the box edges times |d|,
    // which keeps the exact rational point without a division.
    assign w_dm  = w_det[DW-1] ? -w_det : w_det;
    assign w_snx = w_det[DW-1] ? -(NW+1)'(w_nx) : (NW+1)'(w_nx);
    assign w_sny = w_det[DW-1] ? -(NW+1)'(w_ny) : (NW+1)'(w_ny);

    always_comb begin
        w_lo[0] = (w_cpt[PT_AX1] < w_cpt[PT_AX2]) ? w_cpt[PT_AX1] : w_cpt[PT_AX2];
        w_hi[0] = (w_cpt[PT_AX1] < w_cpt[PT_AX2]) ? w_cpt[PT_AX2] : w_cpt[PT_AX1];
        w_lo[1] = (w_cpt[PT_AY1] < w_cpt[PT_AY2]) ? w_cpt[PT_AY1] : w_cpt[PT_AY2];
        w_hi[1] = (w_cpt[PT_AY1] < w_cpt[PT_AY2]) ? w_cpt[PT_AY2] : w_cpt[PT_AY1];
        w_lo[2] = (w_cpt[PT_BX1] < w_cpt[PT_BX2]) ? w_cpt[PT_BX1] : w_cpt[PT_BX2];
        w_hi[2] = (w_cpt[PT_BX1] < w_cpt[PT_BX2]) ? w_cpt[PT_BX2] : w_cpt[PT_BX1];
        w_lo[3] = (w_cpt[PT_BY1] < w_cpt[PT_BY2]) ? w_cpt[PT_BY1] : w_cpt[PT_BY2];
        w_hi[3] = (w_cpt[PT_BY1] < w_cpt[PT_BY2]) ? w_cpt[PT_BY2] : w_cpt[PT_BY1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NR; k++) begin
                r5_lo[k] <= w_lo[k] * $signed({1'b0, w_dm});
                r5_hi[k] <= w_hi[k] * $signed({1'b0, w_dm});
            end
            r5_nx  <= w_snx;
            r5_ny  <= w_sny;
            r5_par <= (w_det == '0);
        end
    end

    // Ranges 0 and 2 are x ranges, 1 and 3 are y ranges.
    assign w_in_box = (r5_lo[0] <= PW'(r5_nx)) && (PW'(r5_nx) <= r5_hi[0]) &&
                      (r5_lo[1] <= PW'(r5_ny)) && (PW'(r5_ny) <= r5_hi[1]) &&
                      (r5_lo[2] <= PW'(r5_nx)) && (PW'(r5_nx) <= r5_hi[2]) &&
                      (r5_lo[3] <= PW'(r5_ny)) && (PW'(r5_ny) <= r5_hi[3]);

    // The flags wait beside the divider until the quotients arrive.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_side.hit   <= w_in_box & ~r5_par;
            r6_side.par   <= r5_par;
            r_side_dly[0] <= r6_side;
            for (int k = 1; k <= OW; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vchain <= '0;
        end else if (w_en) begin
            r_vchain <= {r_vchain[OW+2:0], w_cvalid};
        end
    end

    // Output register: a parallel pair reports a zero point.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= r_side_dly[OW].hit;
            r_par <= r_side_dly[OW].par;
            r_cx  <= r_side_dly[OW].par ? '0 : w_qx;
            r_cy  <= r_side_dly[OW].par ? '0 : w_qy;
        end
    end

    assign o_valid       = r_vchain[OW+3];
    assign o_hit         = r_hit;
    assign o_is_parallel = r_par;
    assign o_cross_x     = r_cx;
    assign o_cross_y     = r_cy;

    // A parallel pair never reports a hit or a nonzero point.
    a_par_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_parallel |-> !o_hit && o_cross_x == '0 && o_cross_y == '0)
        else $error("parallel item with hit or nonzero point");

    // The input is held back only while an item waits at the output.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting item");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid item right after reset");

    // A held output item keeps its flags.
    a_hold_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_is_parallel))
        else $error("held item changed");

endmodule

// ===== dv/tb_segment_intersection_core.sv =====
// Self-checking testbench for the segment intersection core.
`timescale 1ns / 1ps
module tb_segment_intersection_core;
    import sgi_pkg::*;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
    // Depth of the core's pipeline, from an accepted item to its result.
    localparam int LATENCY    = COORD_BITS + FRAC_BITS + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD  = 300;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef coord_t coord_arr_t [NUM_PTS];

    typedef struct {
        logic                      hit;
        logic                      par;
        logic signed [OUT_BITS-1:0] cx;
        logic signed [OUT_BITS-1:0] cy;
    } crossing_t;

    // Stall patterns of the receiver.
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    coord_t i_seg_a_start_x = '0, i_seg_a_start_y = '0, i_seg_a_end_x = '0, i_seg_a_end_y = '0;
    coord_t i_seg_b_start_x = '0, i_seg_b_start_y = '0, i_seg_b_end_x = '0, i_seg_b_end_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_hit, o_is_parallel;
    logic signed [OUT_BITS-1:0] o_cross_x, o_cross_y;

    crossing_t   pending_crossings[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    stall_mode_t stall_mode = STALL_NONE;
    bit          hold_request = 1'b0;
    int          max_gap = 0;
    int          burst_left = 0;

    segment_intersection_core #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_seg_a_start_x(i_seg_a_start_x),
        .i_seg_a_start_y(i_seg_a_start_y),
        .i_seg_a_end_x  (i_seg_a_end_x),
        .i_seg_a_end_y  (i_seg_a_end_y),
        .i_seg_b_start_x(i_seg_b_start_x),
        .i_seg_b_start_y(i_seg_b_start_y),
        .i_seg_b_end_x  (i_seg_b_end_x),
        .i_seg_b_end_y  (i_seg_b_end_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_is_parallel  (o_is_parallel),
        .o_cross_x      (o_cross_x),
        .o_cross_y      (o_cross_y)
    );

    always #5 i_clk = ~i_clk;

    // The run is bounded so that a hung pipeline cannot stall the regression.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Exact quotient num * 2^FRAC_BITS / den, truncated toward zero, then
    // clamped into the output word.
    function automatic logic signed [OUT_BITS-1:0] fixed_quotient(wide_t num, longint den);
        wide_t q;
        q = (num <<< FRAC_BITS) / wide_t'(den);
        if (q > wide_t'((64'sd1 <<< (OUT_BITS - 1)) - 1))
            q = wide_t'((64'sd1 <<< (OUT_BITS - 1)) - 1);
        else if (q < -wide_t'(64'sd1 <<< (OUT_BITS - 1)))
            q = -wide_t'(64'sd1 <<< (OUT_BITS - 1));
        return q[OUT_BITS-1:0];
    endfunction

    // True when num / den lies in the closed span between p and q.
    function automatic bit within_span(wide_t num, longint den, longint p, longint q);
        wide_t  n;
        wide_t  dm;
        longint lo, hi;
        n  = (den < 0) ? -num : num;
        dm = (den < 0) ? -wide_t'(den) : wide_t'(den);
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        return (wide_t'(lo) * dm <= n) && (n <= wide_t'(hi) * dm);
    endfunction

    function automatic crossing_t predict_crossing(coord_arr_t pt);
        longint    ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        longint    a1, b1, c1, a2, b2, c2, det;
        wide_t     nx, ny;
        crossing_t r;
        ax1 = pt[PT_AX1]; ay1 = pt[PT_AY1]; ax2 = pt[PT_AX2]; ay2 = pt[PT_AY2];
        bx1 = pt[PT_BX1]; by1 = pt[PT_BY1]; bx2 = pt[PT_BX2]; by2 = pt[PT_BY2];
        a1 = ay2 - ay1; b1 = ax1 - ax2; c1 = ay1 * ax2 - ax1 * ay2;
        a2 = by2 - by1; b2 = bx1 - bx2; c2 = by1 * bx2 - bx1 * by2;
        det = a1 * b2 - a2 * b1;
        if (det == 0) begin
            r.hit = 1'b0; r.par = 1'b1; r.cx = '0; r.cy = '0;
            return r;
        end
        nx = wide_t'(c2) * wide_t'(b1) - wide_t'(c1) * wide_t'(b2);
        ny = wide_t'(a2) * wide_t'(c1) - wide_t'(a1) * wide_t'(c2);
        r.par = 1'b0;
        r.hit = within_span(nx, det, ax1, ax2) && within_span(ny, det, ay1, ay2) &&
                within_span(nx, det, bx1, bx2) && within_span(ny, det, by1, by2);
        r.cx  = fixed_quotient(nx, det);
        r.cy  = fixed_quotient(ny, det);
        return r;
    endfunction

    // Offers one item and holds it until the core takes it. Valid is only
    // lowered when a gap follows, so back-to-back items never see a glitch.
    task automatic send_pair(coord_arr_t pt);
        int gap;
        i_valid         <= 1'b1;
        i_seg_a_start_x <= pt[PT_AX1];
        i_seg_a_start_y <= pt[PT_AY1];
        i_seg_a_end_x   <= pt[PT_AX2];
        i_seg_a_end_y   <= pt[PT_AY2];
        i_seg_b_start_x <= pt[PT_BX1];
        i_seg_b_start_y <= pt[PT_BY1];
        i_seg_b_end_x   <= pt[PT_BX2];
        i_seg_b_end_y   <= pt[PT_BY2];
        do @(posedge i_clk); while (o_stall);
        pending_crossings.push_back(predict_crossing(pt));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // The receiver stalls on its own pattern; a hold request makes it keep
    // stall high for a long, self-counted stretch.
    always @(posedge i_clk) begin : stall_driver
        int hold_left;
        if (hold_request && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_request <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 99) < 20);
                default:     i_stall <= ($urandom_range(0, 99) < 60);
            endcase
        end
    end

    // Every result taken by the receiver is checked against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin : result_checker
        crossing_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_crossings.size() == 0) begin
                $error("unexpected result: hit=%0b par=%0b x=%0d y=%0d",
                       o_hit, o_is_parallel, o_cross_x, o_cross_y);
                fail_count++;
            end else begin
                want = pending_crossings.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, o_hit);
                    fail_count++;
                end
                if (o_is_parallel !== want.par) begin
                    $error("is_parallel: expected %0b, got %0b", want.par, o_is_parallel);
                    fail_count++;
                end
                if (o_cross_x !== want.cx) begin
                    $error("cross_x: expected %0d, got %0d", want.cx, o_cross_x);
                    fail_count++;
                end
                if (o_cross_y !== want.cy) begin
                    $error("cross_y: expected %0d, got %0d", want.cy, o_cross_y);
                    fail_count++;
                end
            end
        end
    end

    function automatic coord_t rand_coord(int span);
        if (span <= 0) return coord_t'($urandom);
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    // Builds a pair from eight coordinates given in segment order.
    function automatic coord_arr_t make_pair(int v0, int v1, int v2, int v3,
                                             int v4, int v5, int v6, int v7);
        coord_arr_t pt;
        pt[PT_AX1] = coord_t'(v0); pt[PT_AY1] = coord_t'(v1);
        pt[PT_AX2] = coord_t'(v2); pt[PT_AY2] = coord_t'(v3);
        pt[PT_BX1] = coord_t'(v4); pt[PT_BY1] = coord_t'(v5);
        pt[PT_BX2] = coord_t'(v6); pt[PT_BY2] = coord_t'(v7);
        return pt;
    endfunction

    task automatic test_directed();
        stall_mode = STALL_NONE;
        max_gap = 0;
        // Plain crossing inside both boxes and one with a fractional point.
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(make_pair(0, 0, 3, 1, 0, 1, 1, 0));
        // Crossing exactly on an endpoint, so the box edge must count.
        send_pair(make_pair(0, 0, 4, 4, 4, 4, 8, 0));
        // Lines cross, but outside both segments.
        send_pair(make_pair(0, 0, 1, 1, 5, 0, 6, -1));
        // Parallel, coincident and zero-length segments.
        send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(make_pair(0, 0, 10, 10, 2, 2, 7, 7));
        send_pair(make_pair(3, 3, 3, 3, 0, 10, 10, 0));
        send_pair(make_pair(5, -5, 5, -5, 5, -5, 5, -5));
        // Coordinate extremes.
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_pair(make_pair(-32768, -32768, -32768, 32767, -32768, -32768, 32767, -32768));
        // Nearly parallel lines whose crossing lies far away and saturates.
        send_pair(make_pair(0, 0, 32767, 1, 0, 1, 32766, 2));
        send_pair(make_pair(0, 0, -32768, 1, 0, 1, -32767, 2));
        send_pair(make_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 3));
        send_pair(make_pair(0, 0, 32767, -1, 0, -1, 32766, -2));
        // A negative crossing with a fraction and a mixed-sign one, to check truncation toward zero.
        send_pair(make_pair(0, 0, -3, -1, 0, -1, -1, 0));
        send_pair(make_pair(-1, 0, -1, 7, -4, 2, 3, 3));
    endtask

    task automatic test_random_mixed(int count);
        coord_arr_t pt;
        int         kind;
        stall_mode = STALL_LIGHT;
        max_gap = 4;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < NUM_PTS; k++)
                pt[k] = (kind < 4) ? rand_coord(0) : rand_coord(64);
            // Some pairs are forced parallel or degenerate on purpose.
            if (kind == 9) begin
                pt[PT_BX2] = pt[PT_BX1] + (pt[PT_AX2] - pt[PT_AX1]);
                pt[PT_BY2] = pt[PT_BY1] + (pt[PT_AY2] - pt[PT_AY1]);
            end else if (kind == 8) begin
                pt[PT_AX2] = pt[PT_AX1];
                pt[PT_AY2] = pt[PT_AY1];
            end
            send_pair(pt);
        end
    endtask

    task automatic test_heavy_stall(int count);
        coord_arr_t pt;
        stall_mode = STALL_HEAVY;
        max_gap = 2;
        repeat (count) begin
            for (int k = 0; k < NUM_PTS; k++)
                pt[k] = $urandom_range(0, 1) ? rand_coord(0) : rand_coord(16);
            send_pair(pt);
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill while the
    // sender keeps offering back-to-back items.
    task automatic test_backpressure(int count);
        coord_arr_t pt;
        stall_mode = STALL_NONE;
        max_gap = 0;
        hold_request <= 1'b1;
        repeat (count) begin
            for (int k = 0; k < NUM_PTS; k++)
                pt[k] = rand_coord(200);
            send_pair(pt);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mixed(500);
        test_backpressure(150);
        test_heavy_stall(200);
        test_random_mixed(200);
        i_valid <= 1'b0;
        stall_mode = STALL_LIGHT;
        while (pending_crossings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0 && pending_crossings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
